### rtl/core/lpst_pkg.sv
// ----------------------------------------------------------------------------
// lpst_pkg
// shared types and constants for the led strip pixel store and transmitter
// ----------------------------------------------------------------------------
package lpst_pkg;

	localparam int NUM_PIXELS_DEF      = 8;
	localparam int BIT_TICKS_DEF       = 20;
	localparam int ONE_HIGH_TICKS_DEF  = 13;
	localparam int ZERO_HIGH_TICKS_DEF = 5;
	localparam int LATCH_TICKS_DEF     = 800;

	localparam int MODE_W  = 2;
	localparam int INDEX_W = 10;
	localparam int COLOR_W = 24;
	localparam int BYTE_W  = 8;
	localparam int FAC_W   = 16;
	localparam int DIV_STEPS = FAC_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BRIGHT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SHOW   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd3;

	localparam logic [BYTE_W-1:0] CODE_RESET = 8'd255;
	localparam logic [2:0]        BIT_MSB    = 3'd7;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_WRITE,
		ST_DIV,
		ST_SCALE_RD,
		ST_SCALE_WR,
		ST_FETCH,
		ST_LOAD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [INDEX_W-1:0] pixel_index;
		logic [COLOR_W-1:0] color;
	} cmd_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic refused;
	} res_t;

endpackage

### rtl/core/lpst_ram.sv
// ----------------------------------------------------------------------------
// lpst_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lpst_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 24,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/led_strip_pixel_store_transmitter_top.sv
// ----------------------------------------------------------------------------
// led_strip_pixel_store_transmitter_top
// grb pixel store with brightness scaling and one-wire serial bit timing
// ----------------------------------------------------------------------------
//  channel | signals                    | payload
//  cmd     | cmd_valid / cmd_ready      | mode, pixel_index, color
//  res     | res_valid / res_ready      | line_level, busy_res, refused
//
//  one transaction at a time; a tick reads a new byte from the store when one
//  is due, a brightness change runs 16 divider steps (none from setting 0) and
//  then rescales every stored byte on the shared multiplier
//  after reset a clearing pass writes zero to all 3*NUM_PIXELS store bytes,
//  one per cycle, with cmd_ready low
//  a waiting result holds its transaction in done, so it also stalls the next cmd transaction
// ----------------------------------------------------------------------------
module led_strip_pixel_store_transmitter_top #(
	parameter int NUM_PIXELS      = lpst_pkg::NUM_PIXELS_DEF,
	parameter int BIT_TICKS       = lpst_pkg::BIT_TICKS_DEF,
	parameter int ONE_HIGH_TICKS  = lpst_pkg::ONE_HIGH_TICKS_DEF,
	parameter int ZERO_HIGH_TICKS = lpst_pkg::ZERO_HIGH_TICKS_DEF,
	parameter int LATCH_TICKS     = lpst_pkg::LATCH_TICKS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  lpst_pkg::cmd_t  cmd,
	output logic            res_valid,
	input  logic            res_ready,
	output lpst_pkg::res_t  res
);

	localparam int STORE_BYTES = 3 * NUM_PIXELS;
	localparam int AW = $clog2(STORE_BYTES);
	localparam int TW = $clog2(BIT_TICKS);
	localparam int GW = $clog2(LATCH_TICKS + 1);
	localparam int PW = lpst_pkg::BYTE_W + lpst_pkg::FAC_W;
	localparam logic [AW-1:0] LAST_BYTE = AW'(STORE_BYTES - 1);
	localparam logic [TW-1:0] LAST_TICK = TW'(BIT_TICKS - 1);
	localparam logic [GW-1:0] GAP_LOAD  = GW'(LATCH_TICKS);

	lpst_pkg::state_t state_q, state_d;
	lpst_pkg::cmd_t   cmd_q;
	lpst_pkg::res_t   res_q;
	logic             res_valid_q;

	logic [1:0]                      wcnt_q;
	logic [AW-1:0]                   idx_q;
	logic [lpst_pkg::DIV_CNT_W-1:0]  div_cnt_q;
	logic [lpst_pkg::FAC_W-1:0]      fac_q;
	logic [lpst_pkg::BYTE_W-1:0]     rem_q;
	logic [lpst_pkg::BYTE_W-1:0]     newc_q;
	logic [lpst_pkg::BYTE_W-1:0]     code_q;
	logic [lpst_pkg::BYTE_W-1:0]     cur_byte_q;
	logic [AW-1:0]                   byte_pos_q;
	logic [2:0]                      bit_q;
	logic [TW-1:0]                   tick_q;
	logic                            sending_q;
	logic                            pending_q;
	logic [GW-1:0]                   gap_q;
	logic                            refused_q;

	// shared multiplier
	logic [lpst_pkg::BYTE_W-1:0]            mul_a;
	logic [lpst_pkg::FAC_W-1:0]             mul_b;
	logic [lpst_pkg::BYTE_W+lpst_pkg::FAC_W-1:0] prod;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [lpst_pkg::BYTE_W-1:0] ram_wdata;
	logic [AW-1:0]               ram_raddr;
	logic [lpst_pkg::BYTE_W-1:0] ram_rdata;

	logic [lpst_pkg::BYTE_W-1:0] color_byte;
	logic [lpst_pkg::BYTE_W-1:0] newc;
	logic [lpst_pkg::BYTE_W-1:0] divisor;
	logic [lpst_pkg::BYTE_W:0]   trial;
	logic                        trial_ok;
	logic [11:0]                 base_full;
	logic                        idx_ok;
	logic                        tick_wrap;
	logic [GW-1:0]               gap_nx;
	logic                        start_show;
	logic                        need_fetch;
	logic                        level;

	lpst_ram #(
		.WIDTH (lpst_pkg::BYTE_W),
		.DEPTH (STORE_BYTES),
		.ADDR_W(AW)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign prod = PW'(mul_a) * PW'(mul_b);

	assign newc      = cmd_q.color[7:0] + 8'd1;
	assign divisor   = code_q - 8'd1;
	assign trial     = {rem_q, fac_q[lpst_pkg::FAC_W-1]};
	assign trial_ok  = trial >= {1'b0, divisor};
	assign base_full = {2'b00, cmd_q.pixel_index} + {1'b0, cmd_q.pixel_index, 1'b0};
	assign idx_ok    = 32'(cmd_q.pixel_index) < 32'(NUM_PIXELS);
	assign tick_wrap = tick_q == LAST_TICK;
	assign gap_nx    = (gap_q != '0) ? gap_q - GW'(1) : gap_q;
	assign start_show = !sending_q && (gap_nx == '0) && pending_q;
	assign need_fetch = start_show
		|| (sending_q && tick_wrap && (bit_q == 3'd0) && (byte_pos_q != LAST_BYTE));
	assign level = sending_q && (32'(tick_q) < (cur_byte_q[bit_q] ?
		32'(ONE_HIGH_TICKS) : 32'(ZERO_HIGH_TICKS)));

	always_comb begin
		case (wcnt_q)
			2'd0:    color_byte = cmd_q.color[15:8];
			2'd1:    color_byte = cmd_q.color[23:16];
			default: color_byte = cmd_q.color[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpst_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_raddr = byte_pos_q;
		mul_a     = color_byte;
		mul_b     = {8'd0, code_q};
		case (state_q)
			lpst_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				if (idx_q == LAST_BYTE) begin
					state_d = lpst_pkg::ST_IDLE;
				end
			end
			lpst_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = lpst_pkg::ST_EXEC;
				end
			end
			lpst_pkg::ST_EXEC: begin
				state_d = lpst_pkg::ST_DONE;
				if (cmd_q.mode == lpst_pkg::MODE_TICK) begin
					if (need_fetch) begin
						state_d = lpst_pkg::ST_FETCH;
					end
				end else if (!sending_q) begin
					case (cmd_q.mode)
						lpst_pkg::MODE_WRITE: begin
							if (idx_ok) begin
								state_d = lpst_pkg::ST_WRITE;
							end
						end
						lpst_pkg::MODE_BRIGHT: begin
							if (newc != code_q) begin
								state_d = (code_q == 8'd1) ? lpst_pkg::ST_SCALE_RD
									: lpst_pkg::ST_DIV;
							end
						end
						default: state_d = lpst_pkg::ST_DONE;
					endcase
				end
			end
			lpst_pkg::ST_WRITE: begin
				ram_we    = 1'b1;
				ram_wdata = (code_q == 8'd0) ? color_byte : prod[15:8];
				if (wcnt_q == 2'd2) begin
					state_d = lpst_pkg::ST_DONE;
				end
			end
			lpst_pkg::ST_DIV: begin
				if (div_cnt_q == lpst_pkg::DIV_CNT_W'(lpst_pkg::DIV_STEPS - 1)) begin
					state_d = lpst_pkg::ST_SCALE_RD;
				end
			end
			lpst_pkg::ST_SCALE_RD: begin
				ram_raddr = idx_q;
				state_d   = lpst_pkg::ST_SCALE_WR;
			end
			lpst_pkg::ST_SCALE_WR: begin
				mul_a     = ram_rdata;
				mul_b     = fac_q;
				ram_we    = 1'b1;
				ram_wdata = prod[15:8];
				state_d   = (idx_q == LAST_BYTE) ? lpst_pkg::ST_DONE : lpst_pkg::ST_SCALE_RD;
			end
			lpst_pkg::ST_FETCH: begin
				state_d = lpst_pkg::ST_LOAD;
			end
			lpst_pkg::ST_LOAD: begin
				state_d = lpst_pkg::ST_DONE;
			end
			lpst_pkg::ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					state_d = lpst_pkg::ST_IDLE;
				end
			end
			default: state_d = lpst_pkg::ST_IDLE;
		endcase
	end

	// control and transmit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			code_q      <= lpst_pkg::CODE_RESET;
			byte_pos_q  <= '0;
			bit_q       <= lpst_pkg::BIT_MSB;
			tick_q      <= '0;
			sending_q   <= 1'b0;
			pending_q   <= 1'b0;
			gap_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				lpst_pkg::ST_CLEAR: begin
					idx_q <= (idx_q == LAST_BYTE) ? '0 : idx_q + AW'(1);
				end
				lpst_pkg::ST_EXEC: begin
					if (cmd_q.mode == lpst_pkg::MODE_TICK) begin
						if (sending_q) begin
							if (tick_wrap) begin
								tick_q <= '0;
								if (bit_q == 3'd0) begin
									bit_q <= lpst_pkg::BIT_MSB;
									if (byte_pos_q == LAST_BYTE) begin
										byte_pos_q <= '0;
										sending_q  <= 1'b0;
										gap_q      <= GAP_LOAD;
									end else begin
										byte_pos_q <= byte_pos_q + AW'(1);
									end
								end else begin
									bit_q <= bit_q - 3'd1;
								end
							end else begin
								tick_q <= tick_q + TW'(1);
							end
						end else begin
							gap_q <= gap_nx;
							if (start_show) begin
								pending_q  <= 1'b0;
								sending_q  <= 1'b1;
								byte_pos_q <= '0;
								bit_q      <= lpst_pkg::BIT_MSB;
								tick_q     <= '0;
							end
						end
					end else if (!sending_q) begin
						if (cmd_q.mode == lpst_pkg::MODE_SHOW) begin
							pending_q <= 1'b1;
						end
						idx_q <= (cmd_q.mode == lpst_pkg::MODE_WRITE) ? base_full[AW-1:0] : '0;
					end
				end
				lpst_pkg::ST_WRITE: begin
					idx_q <= idx_q + AW'(1);
				end
				lpst_pkg::ST_SCALE_WR: begin
					if (idx_q == LAST_BYTE) begin
						idx_q  <= '0;
						code_q <= newc_q;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				lpst_pkg::ST_DONE: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			lpst_pkg::ST_IDLE: begin
				cmd_q <= cmd;
			end
			lpst_pkg::ST_EXEC: begin
				refused_q <= sending_q && (cmd_q.mode != lpst_pkg::MODE_TICK);
				wcnt_q    <= 2'd0;
				newc_q    <= newc;
				div_cnt_q <= '0;
				rem_q     <= '0;
				fac_q     <= (code_q == 8'd1) ? '0 : {newc, 8'd0} - 16'd1;
			end
			lpst_pkg::ST_WRITE: begin
				wcnt_q <= wcnt_q + 2'd1;
			end
			lpst_pkg::ST_DIV: begin
				rem_q     <= trial_ok ? 8'(trial - {1'b0, divisor}) : trial[7:0];
				fac_q     <= {fac_q[lpst_pkg::FAC_W-2:0], trial_ok};
				div_cnt_q <= div_cnt_q + lpst_pkg::DIV_CNT_W'(1);
			end
			lpst_pkg::ST_LOAD: begin
				cur_byte_q <= ram_rdata;
			end
			lpst_pkg::ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					res_q.line_level <= level;
					res_q.busy_res   <= sending_q || pending_q;
					res_q.refused    <= refused_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_show_not_pending_while_sending: assert property (@(posedge clk) disable iff (!arst_n)
		!(sending_q && pending_q))
		else $error("show pending while a frame is being sent");

	a_code_stable_while_sending: assert property (@(posedge clk) disable iff (!arst_n)
		sending_q |=> $stable(code_q))
		else $error("brightness code changed during a frame");

	a_byte_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		sending_q |-> byte_pos_q <= LAST_BYTE)
		else $error("byte position past the end of the store");

	a_store_untouched_while_sending: assert property (@(posedge clk) disable iff (!arst_n)
		sending_q && $past(sending_q) |-> !ram_we)
		else $error("store written during a frame");

endmodule

### bench/led_strip_pixel_store_transmitter_top_test.sv
// ----------------------------------------------------------------------------
// led_strip_pixel_store_transmitter_top_test
// self-checking bench for the grb pixel store and one-wire transmitter:
// a queue-fed driver sends pixel writes, brightness changes, show requests
// and ticks with random gaps, while a clocked monitor with random stalls
// checks every result against an in-bench model of the store, the brightness
// rescale and the bit timing of the serial line, ending with the first bytes
// of a frame on the line
// ----------------------------------------------------------------------------
module led_strip_pixel_store_transmitter_top_test;

	localparam int STORE_BYTES = lpst_pkg::NUM_PIXELS_DEF * 3;
	localparam int RAND_ITEMS  = 460;
	localparam int SEND_TICKS  = 340;
	localparam int ITEM_CYCLES = 500;

	logic           clk;
	logic           arst_n    = 1'b0;
	logic           cmd_valid = 1'b0;
	logic           cmd_ready;
	lpst_pkg::cmd_t cmd       = '0;
	logic           res_valid;
	logic           res_ready = 1'b0;
	lpst_pkg::res_t res;

	// model of the strip
	logic [7:0]  px_store [STORE_BYTES] = '{default: 8'd0};
	logic [7:0]  bright_code = lpst_pkg::CODE_RESET;
	int          byte_pos    = 0;
	logic [2:0]  bit_pos     = lpst_pkg::BIT_MSB;
	int          tick_pos    = 0;
	bit          tx_active   = 1'b0;
	bit          show_wait   = 1'b0;
	int          latch_left  = 0;

	lpst_pkg::cmd_t pend_q [$];
	lpst_pkg::res_t strip_res_q [$];

	int             queued    = 0;
	int             mixed_cnt = 0;
	int             err_cnt   = 0;
	int             res_seen  = 0;
	int             cyc_cnt   = 0;
	int             tx_hold   = 0;
	int             rx_hold   = 0;
	bit             tx_calm   = 1'b0;
	bit             rx_calm   = 1'b0;
	bit             tx_keep;
	bit             tx_load;
	bit             rx_take;
	lpst_pkg::cmd_t tx_next;
	lpst_pkg::res_t want;

	led_strip_pixel_store_transmitter_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] scale_color(input logic [7:0] c);
		if (bright_code == 8'd0) begin
			return c;
		end
		return 8'((int'(c) * int'(bright_code)) >> 8);
	endfunction

	function automatic lpst_pkg::res_t strip_step(input lpst_pkg::cmd_t c);
		lpst_pkg::res_t r;
		int   newc;
		int   oldv;
		int   fac;
		int   base;
		int   hi;
		bit   rej;
		rej = 1'b0;
		if (c.mode == lpst_pkg::MODE_TICK) begin
			if (tx_active) begin
				tick_pos++;
				if (tick_pos >= lpst_pkg::BIT_TICKS_DEF) begin
					tick_pos = 0;
					if (bit_pos == 3'd0) begin
						bit_pos = lpst_pkg::BIT_MSB;
						byte_pos++;
						if (byte_pos >= STORE_BYTES) begin
							byte_pos    = 0;
							tx_active   = 1'b0;
							latch_left  = lpst_pkg::LATCH_TICKS_DEF;
						end
					end else begin
						bit_pos--;
					end
				end
			end else begin
				if (latch_left > 0) begin
					latch_left--;
				end
				if (latch_left == 0 && show_wait) begin
					show_wait = 1'b0;
					tx_active = 1'b1;
					byte_pos  = 0;
					bit_pos   = lpst_pkg::BIT_MSB;
					tick_pos  = 0;
				end
			end
		end else if (tx_active) begin
			rej = 1'b1;
		end else if (c.mode == lpst_pkg::MODE_WRITE) begin
			if (c.pixel_index < lpst_pkg::NUM_PIXELS_DEF) begin
				base = int'(c.pixel_index) * 3;
				px_store[base]     = scale_color(c.color[15:8]);
				px_store[base + 1] = scale_color(c.color[23:16]);
				px_store[base + 2] = scale_color(c.color[7:0]);
			end
		end else if (c.mode == lpst_pkg::MODE_BRIGHT) begin
			newc = (int'(c.color[7:0]) + 1) % 256;
			if (newc != int'(bright_code)) begin
				oldv = (int'(bright_code) + 255) % 256;
				if (oldv == 0) begin
					fac = 0;
				end else if (c.color[7:0] == 8'hFF) begin
					fac = 65535 / oldv;
				end else begin
					fac = ((newc * 256 - 1) & 16'hFFFF) / oldv;
				end
				for (int i = 0; i < STORE_BYTES; i++) begin
					px_store[i] = 8'((int'(px_store[i]) * fac) >> 8);
				end
				bright_code = 8'(newc);
			end
		end else begin
			show_wait = 1'b1;
		end
		r.line_level = 1'b0;
		if (tx_active && byte_pos < STORE_BYTES) begin
			hi = px_store[byte_pos][bit_pos] ? lpst_pkg::ONE_HIGH_TICKS_DEF
				: lpst_pkg::ZERO_HIGH_TICKS_DEF;
			r.line_level = (tick_pos < hi);
		end
		r.busy_res = tx_active || show_wait;
		r.refused  = rej;
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			tx_hold = 0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				strip_res_q.push_back(strip_step(cmd));
			end
			tx_keep = cmd_valid && !cmd_ready;
			tx_load = 1'b0;
			if (!tx_keep) begin
				if (tx_hold > 0) begin
					tx_hold--;
				end else if (pend_q.size() > 0) begin
					tx_next = pend_q.pop_front();
					tx_load = 1'b1;
					tx_hold = tx_calm ? 0 : idle_len();
				end
			end
			cmd_valid <= tx_keep || tx_load;
			if (tx_load) begin
				cmd <= tx_next;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				res_seen++;
				if (strip_res_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10) begin
						$display("result %0d: unexpected, level %0b busy %0b refused %0b",
							res_seen, res.line_level, res.busy_res, res.refused);
					end
				end else begin
					want = strip_res_q.pop_front();
					if (res.line_level !== want.line_level || res.busy_res !== want.busy_res ||
						res.refused !== want.refused) begin
						err_cnt++;
						if (err_cnt <= 10) begin
							$display(
								"result %0d: expected %0b/%0b/%0b, got %0b/%0b/%0b (lvl/busy/ref)",
								res_seen, want.line_level, want.busy_res, want.refused,
								res.line_level, res.busy_res, res.refused);
						end
					end
				end
			end
			if (rx_hold > 0) begin
				rx_hold--;
				rx_take = 1'b0;
			end else begin
				rx_take = 1'b1;
				if (!rx_calm && $urandom_range(0, 2) == 0) begin
					rx_hold = idle_len();
				end
			end
			res_ready <= rx_take;
		end
	end

	initial begin
		while (cyc_cnt <= 2000 + ITEM_CYCLES * queued) begin
			@(posedge clk);
			cyc_cnt++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic put(input logic [lpst_pkg::MODE_W-1:0] m, input int idx,
		input logic [lpst_pkg::COLOR_W-1:0] col);
		lpst_pkg::cmd_t c;
		c.mode        = m;
		c.pixel_index = lpst_pkg::INDEX_W'(idx);
		c.color       = col;
		pend_q.push_back(c);
		queued++;
	endtask

	function automatic logic [lpst_pkg::COLOR_W-1:0] rand_color();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return '0;
		end
		if (r == 1) begin
			return '1;
		end
		return lpst_pkg::COLOR_W'($urandom);
	endfunction

	function automatic int rand_index();
		if ($urandom_range(0, 9) < 8) begin
			return $urandom_range(0, lpst_pkg::NUM_PIXELS_DEF - 1);
		end
		return $urandom_range(0, 1023);
	endfunction

	function automatic logic [7:0] rand_setting();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 8'd0;
		end
		if (r == 1) begin
			return 8'd255;
		end
		if (r == 2) begin
			return 8'd254;
		end
		if (r == 3) begin
			return 8'd1;
		end
		return 8'($urandom);
	endfunction

	task automatic put_write();
		put(lpst_pkg::MODE_WRITE, rand_index(), rand_color());
	endtask

	task automatic put_bright();
		put(lpst_pkg::MODE_BRIGHT, rand_index(), {16'($urandom), rand_setting()});
	endtask

	task automatic put_tick();
		put(lpst_pkg::MODE_TICK, $urandom_range(0, 1023), lpst_pkg::COLOR_W'($urandom));
	endtask

	task automatic put_show();
		put(lpst_pkg::MODE_SHOW, $urandom_range(0, 1023), lpst_pkg::COLOR_W'($urandom));
	endtask

	task automatic put_request();
		int r;
		r = $urandom_range(0, 2);
		if (r == 0) begin
			put_write();
		end else if (r == 1) begin
			put_bright();
		end else begin
			put_show();
		end
	endtask

	// wait until every queued transaction is sent and answered
	task automatic settle();
		@(posedge clk);
		while (res_seen < queued) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int k;
		int pick;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		put(lpst_pkg::MODE_WRITE, 0, 24'hFFFFFF);
		put(lpst_pkg::MODE_WRITE, lpst_pkg::NUM_PIXELS_DEF - 1, 24'h000000);
		put(lpst_pkg::MODE_WRITE, lpst_pkg::NUM_PIXELS_DEF, 24'hFFFFFF);
		put(lpst_pkg::MODE_WRITE, 1023, 24'hFFFFFF);
		put(lpst_pkg::MODE_WRITE, 1, 24'h80017F);
		put(lpst_pkg::MODE_BRIGHT, 0, 24'h0000FF);
		put(lpst_pkg::MODE_WRITE, 2, 24'hA5C35A);
		put(lpst_pkg::MODE_BRIGHT, 0, 24'hFFFF00);
		put(lpst_pkg::MODE_BRIGHT, 0, 24'h000000);
		put(lpst_pkg::MODE_WRITE, 3, 24'hFFFFFF);
		put(lpst_pkg::MODE_BRIGHT, 0, 24'h000080);
		put(lpst_pkg::MODE_WRITE, 4, 24'h5AA5FF);
		put(lpst_pkg::MODE_BRIGHT, 0, 24'h0000FE);
		put(lpst_pkg::MODE_WRITE, 5, 24'hFF00FF);
		put(lpst_pkg::MODE_WRITE, 6, 24'h00FF00);
		put(lpst_pkg::MODE_TICK, 1023, 24'hFFFFFF);
		put(lpst_pkg::MODE_WRITE, 7, 24'hC0FFEE);
		put(lpst_pkg::MODE_BRIGHT, 3, 24'h00007F);
		put(lpst_pkg::MODE_TICK, 0, 24'h000000);
		put(lpst_pkg::MODE_WRITE, 0, 24'h123456);
		put(lpst_pkg::MODE_BRIGHT, 0, 24'h000010);

		while (mixed_cnt < RAND_ITEMS) begin
			settle();
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(10, 40)) begin
				pick = $urandom_range(0, 99);
				if (pick < 35) begin
					put_tick();
				end else if (pick < 75) begin
					put_write();
				end else if (pick < 90) begin
					put_bright();
				end else begin
					put(lpst_pkg::MODE_WRITE, $urandom_range(lpst_pkg::NUM_PIXELS_DEF, 1023),
						rand_color());
				end
				mixed_cnt++;
			end
		end

		// a frame: show twice, change the store while pending, then run into it
		settle();
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		repeat ($urandom_range(3, 6)) begin
			put(lpst_pkg::MODE_WRITE, $urandom_range(0, lpst_pkg::NUM_PIXELS_DEF - 1),
				rand_color());
		end
		put_show();
		put_show();
		put_write();
		put_bright();
		put_tick();
		for (k = 0; k < SEND_TICKS; k++) begin
			if ($urandom_range(0, 19) == 0) begin
				put_request();
			end
			put_tick();
		end

		settle();
		repeat (80) @(posedge clk);
		if (err_cnt == 0 && strip_res_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
